FILE: rtl/clfm_pkg.sv
// Package for the lambda-from-mean polynomial block: fixed-point constants,
// coefficient ROM, micro-program ROM and the control/status types.
// No dependencies.
package clfm_pkg;

  // Fixed-point formats
  localparam int INPUT_FRAC_BITS = 32;
  localparam int ACC_FRAC_BITS   = 40;
  localparam int XSHIFT          = ACC_FRAC_BITS - INPUT_FRAC_BITS;
  localparam int POLY_DEGREE     = 18;
  localparam int IDX_W           = 5;

  localparam logic [127:0] DEC18 = 128'd1000000000000000000;
  localparam logic [127:0] DEC9  = 128'd1000000000;
  localparam logic [127:0] LOW_BOUND_E9  = 128'd143853919;
  localparam logic [127:0] HIGH_BOUND_E9 = 128'd856221427;

  // Interval test on the raw mean: m*1e9 >= LOW*2^IFB and m*1e9 <= HIGH*2^IFB
  localparam logic [127:0] MEAN_MIN_W = ((LOW_BOUND_E9 << INPUT_FRAC_BITS) + DEC9 - 1) / DEC9;
  localparam logic [127:0] MEAN_MAX_W = (HIGH_BOUND_E9 << INPUT_FRAC_BITS) / DEC9;
  localparam logic [32:0]  MEAN_MIN   = MEAN_MIN_W[32:0];
  localparam logic [32:0]  MEAN_MAX   = MEAN_MAX_W[32:0];

  localparam logic signed [63:0] INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] INT64_MIN = 64'sh8000_0000_0000_0000;

  // Decimal constant (sign, integer part, 18 fraction digits) to QA,
  // rounding to nearest with ties away from zero
  function automatic logic signed [63:0] to_fixed(input logic neg, input logic [63:0] ip,
                                                  input logic [63:0] fp);
    logic [127:0] num;
    logic [127:0] quo;
    logic [63:0]  mag;
    num = ({64'd0, fp} << ACC_FRAC_BITS) + (DEC18 / 2);
    quo = num / DEC18;
    mag = (ip << ACC_FRAC_BITS) + quo[63:0];
    return neg ? -mag : mag;
  endfunction

  localparam logic signed [63:0] SCALE_Q  = to_fixed(1'b0, 64'd2, 64'd193196000000000000);
  localparam logic signed [63:0] OFFSET_Q = to_fixed(1'b1, 64'd1, 64'd96698000000000560);

  // Coefficients c0..c18 in QA
  localparam logic signed [63:0] COEF_Q [POLY_DEGREE+1] = '{
    to_fixed(1'b0, 64'd0,   64'd499973865804236080),
    to_fixed(1'b0, 64'd1,   64'd368024096854642700),
    to_fixed(1'b1, 64'd0,   64'd924747670069336),
    to_fixed(1'b1, 64'd2,   64'd736078237077606400),
    to_fixed(1'b0, 64'd0,   64'd95109043642878532),
    to_fixed(1'b0, 64'd5,   64'd748377367592183900),
    to_fixed(1'b1, 64'd1,   64'd841998845338821400),
    to_fixed(1'b1, 64'd12,  64'd357242575206328000),
    to_fixed(1'b0, 64'd16,  64'd361405849456787000),
    to_fixed(1'b0, 64'd26,  64'd417928500100970000),
    to_fixed(1'b1, 64'd80,  64'd21261215209961000),
    to_fixed(1'b1, 64'd48,  64'd621550429612398000),
    to_fixed(1'b0, 64'd228, 64'd768722534179690000),
    to_fixed(1'b0, 64'd64,  64'd702439151704311000),
    to_fixed(1'b1, 64'd380, 64'd758743286132810000),
    to_fixed(1'b1, 64'd51,  64'd895506033673882000),
    to_fixed(1'b0, 64'd341, 64'd663604736328120000),
    to_fixed(1'b0, 64'd18,  64'd360968290828168000),
    to_fixed(1'b1, 64'd127, 64'd708103179931640000)
  };

  // Micro-operations and jump conditions
  typedef enum logic [2:0] {
    OP_NOP, OP_WAIT, OP_CHK, OP_MULP, OP_MULC, OP_ADD, OP_FIN
  } clfm_op_t;

  typedef enum logic [2:0] {
    COND_NONE, COND_ALWAYS, COND_NO_IN, COND_OUT_RANGE, COND_LOOP, COND_OUT_BUSY
  } clfm_cond_t;

  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] UPC_WAIT = 4'd0;
  localparam logic [UPC_W-1:0] UPC_CHK  = 4'd1;
  localparam logic [UPC_W-1:0] UPC_LOOP = 4'd5;
  localparam logic [UPC_W-1:0] UPC_FIN  = 4'd8;

  typedef struct packed {
    clfm_op_t         op;
    logic             tsel;   // 1: t = S*x + O, 0: acc = acc*t + c[idx]
    clfm_cond_t       cond;
    logic [UPC_W-1:0] target;
    logic             ret;    // fall through to step 0
  } clfm_ctrl_t;

  typedef struct packed {
    logic out_range;
    logic loop_more;
    logic out_busy;
  } clfm_status_t;

  // Micro-program
  function automatic clfm_ctrl_t ucode(input logic [UPC_W-1:0] pc);
    clfm_ctrl_t w;
    w = '{op: OP_NOP, tsel: 1'b0, cond: COND_ALWAYS, target: UPC_WAIT, ret: 1'b0};
    unique case (pc)
      4'd0: w = '{op: OP_WAIT, tsel: 1'b0, cond: COND_NO_IN,     target: UPC_WAIT, ret: 1'b0};
      4'd1: w = '{op: OP_CHK,  tsel: 1'b0, cond: COND_OUT_RANGE, target: UPC_FIN,  ret: 1'b0};
      4'd2: w = '{op: OP_MULP, tsel: 1'b1, cond: COND_NONE,      target: UPC_WAIT, ret: 1'b0};
      4'd3: w = '{op: OP_MULC, tsel: 1'b1, cond: COND_NONE,      target: UPC_WAIT, ret: 1'b0};
      4'd4: w = '{op: OP_ADD,  tsel: 1'b1, cond: COND_NONE,      target: UPC_WAIT, ret: 1'b0};
      4'd5: w = '{op: OP_MULP, tsel: 1'b0, cond: COND_NONE,      target: UPC_WAIT, ret: 1'b0};
      4'd6: w = '{op: OP_MULC, tsel: 1'b0, cond: COND_NONE,      target: UPC_WAIT, ret: 1'b0};
      4'd7: w = '{op: OP_ADD,  tsel: 1'b0, cond: COND_LOOP,      target: UPC_LOOP, ret: 1'b0};
      4'd8: w = '{op: OP_FIN,  tsel: 1'b0, cond: COND_OUT_BUSY,  target: UPC_FIN,  ret: 1'b1};
      default: w = '{op: OP_NOP, tsel: 1'b0, cond: COND_ALWAYS, target: UPC_WAIT, ret: 1'b0};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/clfm_useq.sv
// Micro-sequencer: step counter, program ROM lookup and conditional jumps.
// Depends on clfm_pkg.
module clfm_useq
  import clfm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  clfm_status_t status,
  output clfm_ctrl_t   ctrl
);

  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  logic             take;

  assign ctrl = ucode(upc);

  // Jump condition
  always_comb begin
    unique case (ctrl.cond)
      COND_NONE:      take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_NO_IN:     take = !in_valid;
      COND_OUT_RANGE: take = status.out_range;
      COND_LOOP:      take = status.loop_more;
      COND_OUT_BUSY:  take = status.out_busy;
      default:        take = 1'b1;
    endcase
  end

  always_comb begin
    if (take) begin
      upc_next = ctrl.target;
    end else if (ctrl.ret) begin
      upc_next = UPC_WAIT;
    end else begin
      upc_next = upc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UPC_WAIT;
    end else begin
      upc <= upc_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_upc_bound: assert property (@(posedge clk) disable iff (rst) upc <= UPC_FIN)
    else $error("step counter beyond program");
  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (upc == UPC_FIN && status.out_busy) |=> upc == UPC_FIN)
    else $error("left finish step while output busy");
  a_wait_hold: assert property (@(posedge clk) disable iff (rst)
    (upc == UPC_WAIT && !in_valid) |=> upc == UPC_WAIT)
    else $error("left wait step without a transfer");
`endif

endmodule

FILE: rtl/clfm_dpath.sv
// Datapath: range test, shared 64x64 multiplier (four 32x32 partials),
// saturating adder, Horner registers and the output register.
// Depends on clfm_pkg.
module clfm_dpath
  import clfm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  clfm_ctrl_t   ctrl,
  input  logic         in_valid,
  input  logic [31:0]  mean_in,
  input  logic         out_stall,
  output clfm_status_t status,
  output logic         out_valid,
  output logic [31:0]  lambda_out,
  output logic         in_range,
  output logic         saturated
);

  localparam logic [127:0] PROD_RND = 128'd1 << (ACC_FRAC_BITS - 1);
  localparam logic [ACC_FRAC_BITS:0] OUT_RND = (ACC_FRAC_BITS+1)'(1) << (ACC_FRAC_BITS - 33);

  logic [31:0]        m;
  logic               rng;
  logic signed [63:0] t;
  logic signed [63:0] acc;
  logic signed [63:0] prod;
  logic [63:0]        pp_ll, pp_lh, pp_hl, pp_hh;
  logic               pneg;
  logic [IDX_W-1:0]   idx;

  logic               range_ok;
  logic signed [63:0] x;
  logic signed [63:0] opa, opb;
  logic [63:0]        maga, magb;
  logic [127:0]       psum;
  logic [63:0]        pres;
  logic               povf;
  logic [63:0]        pres_sat;
  logic signed [63:0] addk;
  logic [64:0]        sum;
  logic signed [63:0] sum_sat;
  logic [ACC_FRAC_BITS:0] rsum;
  logic [31:0]        lam_next;
  logic               sat_next;
  logic               accept;
  logic               fin_go;

  // Interval test and conversion of the mean to QA
  assign range_ok = ({1'b0, m} >= MEAN_MIN) && ({1'b0, m} <= MEAN_MAX);
  assign x        = 64'({32'd0, m} << XSHIFT);

  assign accept   = (ctrl.op == OP_WAIT) && in_valid;
  assign fin_go   = (ctrl.op == OP_FIN) && !(out_valid && out_stall);

  assign status.out_range = !range_ok;
  assign status.loop_more = (idx != '0);
  assign status.out_busy  = out_valid && out_stall;

  // Sign-magnitude operands for the partial products
  assign opa  = ctrl.tsel ? SCALE_Q : acc;
  assign opb  = ctrl.tsel ? x : t;
  assign maga = opa[63] ? 64'(-opa) : 64'(opa);
  assign magb = opb[63] ? 64'(-opb) : 64'(opb);

  // Partial product sum, rounding to QA and saturation
  always_comb begin
    psum = {pp_hh, 64'd0} + ({64'd0, pp_lh} << 32) + ({64'd0, pp_hl} << 32)
         + {64'd0, pp_ll} + PROD_RND;
    pres = psum[ACC_FRAC_BITS+63:ACC_FRAC_BITS];
    povf = (|psum[127:ACC_FRAC_BITS+64]) || pres[63];
    pres_sat = povf ? 64'(INT64_MAX) : pres;
  end

  // Saturating add of the constant term
  always_comb begin
    addk = ctrl.tsel ? OFFSET_Q : COEF_Q[idx];
    sum  = {prod[63], prod} + {addk[63], addk};
    if (sum[64] != sum[63]) begin
      sum_sat = sum[64] ? INT64_MIN : INT64_MAX;
    end else begin
      sum_sat = sum[63:0];
    end
  end

  // Clamp and round the final value to Q0.32
  always_comb begin
    rsum     = {1'b0, acc[ACC_FRAC_BITS-1:0]} + OUT_RND;
    lam_next = 32'd0;
    sat_next = 1'b0;
    if (!rng) begin
      lam_next = 32'd0;
    end else if (acc[63]) begin
      sat_next = 1'b1;
    end else if (|acc[62:ACC_FRAC_BITS]) begin
      lam_next = 32'hFFFF_FFFF;
      sat_next = 1'b1;
    end else if (rsum[ACC_FRAC_BITS]) begin
      lam_next = 32'hFFFF_FFFF;
    end else begin
      lam_next = rsum[ACC_FRAC_BITS-1:ACC_FRAC_BITS-32];
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      m <= mean_in;
    end
    unique case (ctrl.op)
      OP_CHK: begin
        rng <= range_ok;
        acc <= COEF_Q[POLY_DEGREE];
        idx <= IDX_W'(POLY_DEGREE - 1);
      end
      OP_MULP: begin
        pp_ll <= 64'(maga[31:0])  * 64'(magb[31:0]);
        pp_lh <= 64'(maga[31:0])  * 64'(magb[63:32]);
        pp_hl <= 64'(maga[63:32]) * 64'(magb[31:0]);
        pp_hh <= 64'(maga[63:32]) * 64'(magb[63:32]);
        pneg  <= opa[63] ^ opb[63];
      end
      OP_MULC: begin
        prod <= pneg ? 64'(-pres_sat) : 64'(pres_sat);
      end
      OP_ADD: begin
        if (ctrl.tsel) begin
          t <= sum_sat;
        end else begin
          acc <= sum_sat;
          if (idx != '0) begin
            idx <= idx - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      lambda_out <= lam_next;
      in_range   <= rng;
      saturated  <= sat_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !in_range) |-> (lambda_out == 32'd0 && !saturated))
    else $error("out-of-range result not cleared");
  a_sat_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> (lambda_out == 32'd0 || lambda_out == 32'hFFFF_FFFF))
    else $error("saturated result not at a bound");
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_ADD && !ctrl.tsel) |-> idx <= IDX_W'(POLY_DEGREE - 1))
    else $error("coefficient index out of range");
`endif

endmodule

FILE: rtl/cb_lambda_from_mean_poly.sv
// A mean inside the fitted interval takes 19 dependent multiply-adds (t, then 18
// Horner steps) on one shared 64x64 multiplier built from 32x32 partials before
// out_valid; a mean outside it goes from the range test to the finish step. A new
// item is taken only once the sequencer is back at its wait step.
// A finished result waits in the output register while the next item is taken.
// Reset (rst, synchronous) returns the sequencer to its wait step, drops out_valid.
module cb_lambda_from_mean_poly
  import clfm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] mean_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] lambda_out,
  output logic        in_range,
  output logic        saturated
);

  clfm_ctrl_t   ctrl;
  clfm_status_t status;

  // Inputs are taken only on the wait step
  assign in_stall = (ctrl.op != OP_WAIT);

  clfm_useq u_useq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .ctrl     (ctrl)
  );

  clfm_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .in_valid   (in_valid),
    .mean_in    (mean_in),
    .out_stall  (out_stall),
    .status     (status),
    .out_valid  (out_valid),
    .lambda_out (lambda_out),
    .in_range   (in_range),
    .saturated  (saturated)
  );

endmodule
